// ===== hdl/mpbm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// mpbm_pkg
// Shared types and constants of the multi-pattern byte matcher.
// ---------------------------------------------------------------------------
package mpbm_pkg;

    localparam int STATE_COUNT_DEF = 256;
    localparam int ST_W            = 8;
    localparam int SYM_W           = 8;
    localparam int EDGE_ADDR_W     = ST_W + SYM_W;
    localparam int NODE_DEPTH      = 1 << ST_W;
    localparam int EDGE_DEPTH      = 1 << EDGE_ADDR_W;

    localparam logic [1:0] REQ_EDGE = 2'd0;
    localparam logic [1:0] REQ_NODE = 2'd1;
    localparam logic [1:0] REQ_SCAN = 2'd2;

    typedef struct packed {
        logic [1:0]       req_type;
        logic [ST_W-1:0]  state_index;
        logic [SYM_W-1:0] byte_value;
        logic [ST_W-1:0]  next_state;
        logic             edge_valid;
        logic [ST_W-1:0]  fail_state;
        logic             output_mark;
        logic             last_byte;
    } t_in_word;

    typedef struct packed {
        logic match_found;
        logic table_fault;
    } t_out_word;

    // goto table entry
    typedef struct packed {
        logic            valid;
        logic [ST_W-1:0] target;
    } t_edge;

    // per-state entry: failure link and output mark
    typedef struct packed {
        logic [ST_W-1:0] fail_link;
        logic            mark;
    } t_node;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EDGE,
        ST_FAIL,
        ST_MARK,
        ST_FIN
    } t_state_e;

endpackage
`default_nettype wire

// ===== hdl/multi_pattern_byte_matcher_unit.sv =====
// A table write is done in ST_IDLE. A scan byte does a goto read, then for each
// failure link followed a node-memory read and a goto read from the link, then a
// node read of the mark. The final byte of a haystack then loads the result register.
// One word is in flight at a time; the goto/node memory round trip sets the pace.
// Reset: sync, active low; afterwards a clearing pass over the goto memory
// (and node memory) runs with input stalled.
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// multi_pattern_byte_matcher_unit
// Aho-Corasick scanner: goto edges and per-state failure link / output mark
// live in synchronous RAMs; a small FSM walks the automaton per byte.
// ---------------------------------------------------------------------------
module multi_pattern_byte_matcher_unit #(
    parameter int STATE_COUNT = mpbm_pkg::STATE_COUNT_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire mpbm_pkg::t_in_word  i_in_word,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output mpbm_pkg::t_out_word      o_out_word
);

    import mpbm_pkg::*;

    localparam int WALK_W = $clog2(STATE_COUNT + 2);

    t_state_e              r_state, n_state;
    logic [EDGE_ADDR_W-1:0] r_clr_addr;
    logic [ST_W-1:0]       r_cur;
    logic [ST_W-1:0]       r_q;
    logic [WALK_W-1:0]     r_walk;
    logic [SYM_W-1:0]      r_sym;
    logic                  r_last;
    logic                  r_seen_match;
    logic                  r_seen_fault;
    logic                  r_out_valid;
    t_out_word             r_out_word;

    logic                   in_acc;
    logic                   out_free;
    logic                   walk_lim;
    logic [ST_W-1:0]        e_q;

    logic                   goto_we;
    logic [EDGE_ADDR_W-1:0] goto_waddr;
    t_edge                  goto_wdata;
    logic [EDGE_ADDR_W-1:0] goto_raddr;
    t_edge                  goto_rdata;

    logic                   node_we;
    logic [ST_W-1:0]        node_waddr;
    t_node                  node_wdata;
    logic [ST_W-1:0]        node_raddr;
    t_node                  node_rdata;

    function automatic logic in_range(input logic [ST_W-1:0] s);
        return int'(s) < STATE_COUNT;
    endfunction

    function automatic logic [ST_W-1:0] clamp(input logic [ST_W-1:0] s);
        return in_range(s) ? s : '0;
    endfunction

    assign o_in_stall  = (r_state != ST_IDLE);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign walk_lim    = (r_walk == WALK_W'(STATE_COUNT));
    assign e_q         = goto_rdata.valid ? goto_rdata.target : '0;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    mpbm_ram #(
        .WIDTH ($bits(t_edge)),
        .DEPTH (EDGE_DEPTH)
    ) u_goto_ram (
        .i_clk   (i_clk),
        .i_we    (goto_we),
        .i_waddr (goto_waddr),
        .i_wdata (goto_wdata),
        .i_raddr (goto_raddr),
        .o_rdata (goto_rdata)
    );

    mpbm_ram #(
        .WIDTH ($bits(t_node)),
        .DEPTH (NODE_DEPTH)
    ) u_node_ram (
        .i_clk   (i_clk),
        .i_we    (node_we),
        .i_waddr (node_waddr),
        .i_wdata (node_wdata),
        .i_raddr (node_raddr),
        .o_rdata (node_rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (r_clr_addr == '1) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (in_acc && i_in_word.req_type == REQ_SCAN) n_state = ST_EDGE;
            end
            ST_EDGE: begin
                if (goto_rdata.valid || r_q == '0 || walk_lim) n_state = ST_MARK;
                else                                            n_state = ST_FAIL;
            end
            ST_FAIL: n_state = ST_EDGE;
            ST_MARK: n_state = r_last ? ST_FIN : ST_IDLE;
            ST_FIN: begin
                if (out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // memory controls
    always_comb begin
        goto_we    = 1'b0;
        goto_waddr = {i_in_word.state_index, i_in_word.byte_value};
        goto_wdata = '0;
        goto_raddr = {r_cur, i_in_word.byte_value};
        node_we    = 1'b0;
        node_waddr = i_in_word.state_index;
        node_wdata = '0;
        node_raddr = e_q;
        case (r_state)
            ST_CLEAR: begin
                goto_we    = 1'b1;
                goto_waddr = r_clr_addr;
                node_we    = 1'b1;
                node_waddr = r_clr_addr[ST_W-1:0];
            end
            ST_IDLE: begin
                if (in_acc && in_range(i_in_word.state_index)) begin
                    if (i_in_word.req_type == REQ_EDGE) begin
                        goto_we          = 1'b1;
                        goto_wdata.valid = i_in_word.edge_valid;
                        goto_wdata.target = i_in_word.edge_valid ?
                                            clamp(i_in_word.next_state) : '0;
                    end
                    if (i_in_word.req_type == REQ_NODE) begin
                        node_we              = 1'b1;
                        node_wdata.fail_link = clamp(i_in_word.fail_state);
                        node_wdata.mark      = i_in_word.output_mark;
                    end
                end
            end
            ST_EDGE: begin
                // failure walk reads the link of the current state
                if (n_state == ST_FAIL) node_raddr = r_q;
            end
            ST_FAIL: begin
                goto_raddr = {node_rdata.fail_link, r_sym};
            end
            default: ;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_CLEAR;
            r_clr_addr   <= '0;
            r_cur        <= '0;
            r_seen_match <= 1'b0;
            r_seen_fault <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) r_clr_addr <= r_clr_addr + 1'b1;
            if (r_state == ST_EDGE && !goto_rdata.valid && r_q != '0 && walk_lim) begin
                r_seen_fault <= 1'b1;
            end
            if (r_state == ST_MARK) begin
                r_cur <= r_q;
                if (node_rdata.mark) r_seen_match <= 1'b1;
            end
            if (r_state == ST_FIN && out_free) begin
                r_cur        <= '0;
                r_seen_match <= 1'b0;
                r_seen_fault <= 1'b0;
                r_out_valid  <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid  <= 1'b0;
            end
        end
    end

    // walk datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    r_q    <= r_cur;
                    r_walk <= '0;
                    r_sym  <= i_in_word.byte_value;
                    r_last <= i_in_word.last_byte;
                end
            end
            ST_EDGE: begin
                if (n_state == ST_FAIL) r_walk <= r_walk + 1'b1;
                else                    r_q    <= e_q;
            end
            ST_FAIL: r_q <= node_rdata.fail_link;
            ST_FIN: begin
                if (out_free) begin
                    r_out_word.match_found <= r_seen_match;
                    r_out_word.table_fault <= r_seen_fault;
                end
            end
            default: ;
        endcase
    end

    a_accept_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |-> (r_state == ST_IDLE))
        else $error("input word accepted outside idle");

    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EDGE || r_state == ST_FAIL) |-> (r_walk <= WALK_W'(STATE_COUNT)))
        else $error("failure walk counter past limit");

    a_result_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FIN && out_free) |=> (o_out_valid && r_cur == '0 && !r_seen_match))
        else $error("result not loaded or scan state not reset");

    a_clear_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR && r_clr_addr == '1) |=> (r_state == ST_IDLE))
        else $error("clearing pass did not finish");

    a_fault_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_seen_fault && r_state != ST_FIN) |=> r_seen_fault)
        else $error("fault flag dropped inside a haystack");

endmodule
`default_nettype wire

// ===== hdl/mpbm_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// mpbm_ram
// Simple dual-port RAM: one write port, one read port, registered read.
// ---------------------------------------------------------------------------
module mpbm_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire
